>>> rtl/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg: shared definitions for the 30/24 secded codec
// code layout, command and status codes, check-bit helper functions
// ----------------------------------------------------------------------------
package hsc_pkg;

    localparam int CODE_BITS = 30;
    localparam int DATA_BITS = 24;
    localparam int CHK_BITS  = 5;
    localparam int PAR_BIT   = 24;
    localparam int CHK_LOW   = 25;
    localparam int STAT_BITS = 2;

    // packed result word: codeword, data, status from the lowest bit up
    localparam int M_DATA_BITS = CODE_BITS + DATA_BITS + STAT_BITS;
    localparam int S_DATA_BITS = 32;

    typedef logic [CODE_BITS-1:0] code_t;
    typedef logic [DATA_BITS-1:0] data_t;
    typedef logic [CHK_BITS-1:0]  syn_t;
    typedef logic [STAT_BITS-1:0] stat_t;

    // command codes
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // status codes
    localparam stat_t STAT_OK      = 2'd0;
    localparam stat_t STAT_FIXED   = 2'd1;
    localparam stat_t STAT_UNCORR  = 2'd2;

    // fill pattern for uncorrectable words
    localparam logic [7:0] FILL_CHAR = 8'h2D;
    localparam data_t      FILL_WORD = {3{FILL_CHAR}};

    // hamming position of each data bit (non-powers of two from 3 up)
    localparam syn_t DATA_POS [DATA_BITS] = '{
        5'd3,  5'd5,  5'd6,  5'd7,  5'd9,  5'd10, 5'd11, 5'd12,
        5'd13, 5'd14, 5'd15, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21,
        5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29
    };

    // xor of the positions of all set data bits
    function automatic syn_t data_syndrome(input data_t d);
        syn_t s;
        s = '0;
        for (int i = 0; i < DATA_BITS; i++) begin
            if (d[i]) begin
                s = s ^ DATA_POS[i];
            end
        end
        return s;
    endfunction

    // one-hot flip mask for the codeword bit at a given syndrome
    function automatic code_t flip_mask(input syn_t syn);
        code_t m;
        m = '0;
        for (int i = 0; i < DATA_BITS; i++) begin
            if (DATA_POS[i] == syn) begin
                m[i] = 1'b1;
            end
        end
        for (int k = 0; k < CHK_BITS; k++) begin
            if (syn == syn_t'(1 << k)) begin
                m[CHK_LOW+k] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

>>> rtl/hamming_secded_30_24_codec.sv
// ----------------------------------------------------------------------------
// hamming_secded_30_24_codec: extended hamming secded encoder and decoder
// encodes 24 data bits into a 30-bit codeword or checks and corrects one
// ----------------------------------------------------------------------------
// an accepted word is held in the input register, then in the result register
// throughput: one word per cycle while m_tready does not stall; xor logic lies between stages
// backpressure holds the result word, then the input word once that stage is full
// reset: aresetn low clears both stage valid flags, payload is not reset
// ----------------------------------------------------------------------------
module hamming_secded_30_24_codec (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [hsc_pkg::S_DATA_BITS-1:0]    s_tdata,   // word_in[29:0], zero pad
    input  logic                               s_tuser,   // command
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [hsc_pkg::M_DATA_BITS-1:0]    m_tdata    // codeword_out, data_out, status
);

    // stage registers
    logic                  in_valid_reg;
    logic                  in_cmd_reg;
    hsc_pkg::code_t        in_word_reg;
    logic                  out_valid_reg;
    hsc_pkg::code_t        out_code_reg;
    hsc_pkg::data_t        out_data_reg;
    hsc_pkg::stat_t        out_stat_reg;

    logic                  out_load;
    logic                  in_load;

    hsc_pkg::code_t        code_next;
    hsc_pkg::data_t        data_next;
    hsc_pkg::stat_t        stat_next;

    hsc_pkg::data_t        enc_data;
    hsc_pkg::syn_t         enc_chk;
    logic                  enc_par;
    hsc_pkg::syn_t         dec_syn;
    logic                  dec_par_odd;
    hsc_pkg::code_t        dec_fixed;

    // pipeline advance: result stage frees when empty or taken
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (in_load) begin
            in_cmd_reg  <= s_tuser;
            in_word_reg <= s_tdata[hsc_pkg::CODE_BITS-1:0];
        end
    end

    // encode path
    assign enc_data = in_word_reg[hsc_pkg::DATA_BITS-1:0];
    assign enc_chk  = hsc_pkg::data_syndrome(enc_data);
    assign enc_par  = ^enc_data ^ ^enc_chk;

    // decode path: syndrome, overall parity, single-bit fix
    assign dec_syn     = hsc_pkg::data_syndrome(in_word_reg[hsc_pkg::DATA_BITS-1:0])
                         ^ in_word_reg[hsc_pkg::CODE_BITS-1:hsc_pkg::CHK_LOW];
    assign dec_par_odd = ^in_word_reg;
    assign dec_fixed   = in_word_reg ^ hsc_pkg::flip_mask(dec_syn);

    // result select
    always_comb begin
        code_next = in_word_reg;
        data_next = in_word_reg[hsc_pkg::DATA_BITS-1:0];
        stat_next = hsc_pkg::STAT_OK;
        if (in_cmd_reg == hsc_pkg::CMD_ENCODE) begin
            code_next = {enc_chk, enc_par, enc_data};
            data_next = enc_data;
        end else if (dec_syn == '0) begin
            stat_next = hsc_pkg::STAT_OK;
        end else if (!dec_par_odd ||
                     dec_syn >= hsc_pkg::syn_t'(hsc_pkg::CODE_BITS)) begin
            // double error or a syndrome past the last bit
            data_next = hsc_pkg::FILL_WORD;
            stat_next = hsc_pkg::STAT_UNCORR;
        end else begin
            code_next = dec_fixed;
            data_next = dec_fixed[hsc_pkg::DATA_BITS-1:0];
            stat_next = hsc_pkg::STAT_FIXED;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
        if (out_load && in_valid_reg) begin
            out_code_reg <= code_next;
            out_data_reg <= data_next;
            out_stat_reg <= stat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_stat_reg, out_data_reg, out_code_reg};

    // status code never takes the unused value
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_stat_reg == hsc_pkg::STAT_OK ||
                           out_stat_reg == hsc_pkg::STAT_FIXED ||
                           out_stat_reg == hsc_pkg::STAT_UNCORR))
        else $error("result status holds an unused code");

    // good or fixed words report their own low data bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_stat_reg == hsc_pkg::STAT_OK ||
                          out_stat_reg == hsc_pkg::STAT_FIXED)
        |-> (out_data_reg == out_code_reg[hsc_pkg::DATA_BITS-1:0]))
        else $error("data does not match the codeword");

    // uncorrectable words carry the fill pattern
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_stat_reg == hsc_pkg::STAT_UNCORR)
        |-> (out_data_reg == hsc_pkg::FILL_WORD))
        else $error("uncorrectable word without fill pattern");

    // a held input word is not overwritten while the result side stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_load
        |=> in_valid_reg && $stable(in_word_reg) && $stable(in_cmd_reg))
        else $error("stalled input word was overwritten");

endmodule

>>> bench/hamming_secded_30_24_codec_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_secded_30_24_codec_test: self-checking bench for the secded codec
// drives encode and decode words on the input stream and checks every result
// word against a predictor of the code. Directed words cover the corner cases.
// Random words cover clean, single, double and triple bit errors and noise.
// Both sides of the stream idle at random in several phases.
// ----------------------------------------------------------------------------
module hamming_secded_30_24_codec_test;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_WORDS = 1800;
    localparam int PHASES       = 4;

    // one word waiting to be sent, with the idling setup that goes with it
    typedef struct {
        logic           cmd;
        hsc_pkg::code_t word;
        logic           drain_first;
        int             idle_pct;
        int             stall_pct;
    } codec_word_t;

    // expected result of one word
    typedef struct {
        hsc_pkg::code_t codeword;
        hsc_pkg::data_t data;
        hsc_pkg::stat_t status;
    } codec_result_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [hsc_pkg::S_DATA_BITS-1:0] s_tdata  = '0;
    logic                            s_tuser  = hsc_pkg::CMD_ENCODE;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [hsc_pkg::M_DATA_BITS-1:0] m_tdata;

    codec_word_t    queued_words[$];
    codec_result_t  pending_results[$];
    codec_word_t    sent_word;
    logic           sent_cmd;
    hsc_pkg::code_t sent_code;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;

    // settings applied while the initial block fills the queue
    int  fill_idle_pct = 0;
    int  fill_stall_pct = 0;
    logic fill_drain = 1'b0;

    hamming_secded_30_24_codec u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // hamming position of a codeword bit; the overall parity bit has none
    function automatic int bit_position(input int b);
        int p;
        int n;
        if (b == hsc_pkg::PAR_BIT) begin
            return 0;
        end
        if (b >= hsc_pkg::CHK_LOW) begin
            return 1 << (b - hsc_pkg::CHK_LOW);
        end
        p = 2;
        n = -1;
        while (n < b) begin
            p++;
            if ((p & (p - 1)) != 0) begin
                n++;
            end
        end
        return p;
    endfunction

    // xor of the positions of all set bits
    function automatic int position_xor(input hsc_pkg::code_t w);
        int s;
        s = 0;
        for (int b = 0; b < hsc_pkg::CODE_BITS; b++) begin
            if (w[b]) begin
                s = s ^ bit_position(b);
            end
        end
        return s;
    endfunction

    // expected result of one encode or decode word
    function automatic codec_result_t secded_predict(input logic cmd,
                                                     input hsc_pkg::code_t w);
        codec_result_t  r;
        hsc_pkg::data_t d;
        hsc_pkg::syn_t  chk;
        int             syn;
        hsc_pkg::code_t fixed;
        if (cmd == hsc_pkg::CMD_ENCODE) begin
            d = w[hsc_pkg::DATA_BITS-1:0];
            chk = hsc_pkg::syn_t'(position_xor(hsc_pkg::code_t'(d)));
            r.codeword = {chk, ^{d, chk}, d};
            r.data = d;
            r.status = hsc_pkg::STAT_OK;
        end else begin
            syn = position_xor(w);
            if (syn == 0) begin
                // clean syndrome passes through even with a bad parity bit
                r.codeword = w;
                r.data = w[hsc_pkg::DATA_BITS-1:0];
                r.status = hsc_pkg::STAT_OK;
            end else if (!(^w) || syn >= hsc_pkg::CODE_BITS) begin
                // double error, or a syndrome that names no bit
                r.codeword = w;
                r.data = hsc_pkg::FILL_WORD;
                r.status = hsc_pkg::STAT_UNCORR;
            end else begin
                fixed = w;
                for (int b = 0; b < hsc_pkg::CODE_BITS; b++) begin
                    if (b != hsc_pkg::PAR_BIT && bit_position(b) == syn) begin
                        fixed[b] = ~fixed[b];
                    end
                end
                r.codeword = fixed;
                r.data = fixed[hsc_pkg::DATA_BITS-1:0];
                r.status = hsc_pkg::STAT_FIXED;
            end
        end
        return r;
    endfunction

    // codeword for a data value, used to build decode words
    function automatic hsc_pkg::code_t encode_data(input hsc_pkg::data_t d);
        codec_result_t r;
        r = secded_predict(hsc_pkg::CMD_ENCODE, hsc_pkg::code_t'(d));
        return r.codeword;
    endfunction

    task automatic add_word(input logic cmd, input hsc_pkg::code_t w);
        codec_word_t item;
        item.cmd = cmd;
        item.word = w;
        item.drain_first = fill_drain;
        item.idle_pct = fill_idle_pct;
        item.stall_pct = fill_stall_pct;
        queued_words.push_back(item);
        fill_drain = 1'b0;
    endtask

    // driver: offers queued words, records the expectation on each accept
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_results.push_back(secded_predict(sent_cmd, sent_code));
            end
            if (!s_tvalid || s_tready) begin
                if (queued_words.size() > 0
                    && !(queued_words[0].drain_first && pending_results.size() != 0)
                    && $urandom_range(99) >= send_idle_pct) begin
                    sent_word = queued_words.pop_front();
                    sent_cmd = sent_word.cmd;
                    sent_code = sent_word.word;
                    send_idle_pct <= sent_word.idle_pct;
                    recv_stall_pct <= sent_word.stall_pct;
                    s_tvalid <= 1'b1;
                    s_tuser <= sent_word.cmd;
                    s_tdata <= {{(hsc_pkg::S_DATA_BITS - hsc_pkg::CODE_BITS){1'b0}},
                                sent_word.word};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result word against the oldest expectation
    always @(posedge aclk) begin
        codec_result_t  want;
        hsc_pkg::code_t got_code;
        hsc_pkg::data_t got_data;
        hsc_pkg::stat_t got_status;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_code = m_tdata[hsc_pkg::CODE_BITS-1:0];
                got_data = m_tdata[hsc_pkg::CODE_BITS +: hsc_pkg::DATA_BITS];
                got_status = m_tdata[hsc_pkg::CODE_BITS + hsc_pkg::DATA_BITS +:
                                     hsc_pkg::STAT_BITS];
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_tdata);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got_code !== want.codeword) begin
                        $display("%0t: codeword expected %h actual %h",
                                 $time, want.codeword, got_code);
                        error_count++;
                    end
                    if (got_data !== want.data) begin
                        $display("%0t: data expected %h actual %h",
                                 $time, want.data, got_data);
                        error_count++;
                    end
                    if (got_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got_status);
                        error_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        hsc_pkg::code_t base;
        hsc_pkg::code_t w;
        int             kind;
        int             a;
        int             b;
        int             c;

        // directed: extremes and the corner cases of the decoder
        base = encode_data(24'hA5C3F0);
        add_word(hsc_pkg::CMD_ENCODE, '0);
        add_word(hsc_pkg::CMD_ENCODE, '1);
        add_word(hsc_pkg::CMD_ENCODE, 30'h3F00_0000);
        add_word(hsc_pkg::CMD_ENCODE, 30'h0000_0001);
        add_word(hsc_pkg::CMD_ENCODE, 30'h0080_0000);
        add_word(hsc_pkg::CMD_DECODE, base);
        add_word(hsc_pkg::CMD_DECODE, '0);
        add_word(hsc_pkg::CMD_DECODE, '1);
        add_word(hsc_pkg::CMD_DECODE, encode_data('1));
        // single errors in data and check bits
        add_word(hsc_pkg::CMD_DECODE, base ^ hsc_pkg::code_t'(1 << 0));
        add_word(hsc_pkg::CMD_DECODE, base ^ hsc_pkg::code_t'(1 << 23));
        add_word(hsc_pkg::CMD_DECODE, base ^ hsc_pkg::code_t'(1 << 25));
        add_word(hsc_pkg::CMD_DECODE, base ^ hsc_pkg::code_t'(1 << 29));
        // only the parity bit flipped: clean syndrome, word passes through
        add_word(hsc_pkg::CMD_DECODE, base ^ hsc_pkg::code_t'(1 << hsc_pkg::PAR_BIT));
        // double errors
        add_word(hsc_pkg::CMD_DECODE, base ^ hsc_pkg::code_t'(3));
        add_word(hsc_pkg::CMD_DECODE, base ^ hsc_pkg::code_t'(3 << hsc_pkg::PAR_BIT));
        // odd parity with syndrome 30 (positions 16, 8, 6) and 31 (all checks)
        add_word(hsc_pkg::CMD_DECODE,
                 base ^ ((hsc_pkg::code_t'(3) << 28) | hsc_pkg::code_t'(1 << 2)));
        add_word(hsc_pkg::CMD_DECODE,
                 base ^ (hsc_pkg::code_t'(5'h1F) << hsc_pkg::CHK_LOW));
        add_word(hsc_pkg::CMD_DECODE,
                 encode_data('0) ^ (hsc_pkg::code_t'(5'h1F) << hsc_pkg::CHK_LOW));
        // triple error, decoder miscorrects
        add_word(hsc_pkg::CMD_DECODE,
                 base ^ hsc_pkg::code_t'((1 << 3) | (1 << 10) | (1 << 20)));

        // random words in idling phases
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin fill_idle_pct = 0;  fill_stall_pct = 0;  end
                1: begin fill_idle_pct = 68; fill_stall_pct = 0;  end
                2: begin fill_idle_pct = 0;  fill_stall_pct = 68; end
                default: begin fill_idle_pct = 28; fill_stall_pct = 28; end
            endcase
            // hold off until every result so far has come back
            fill_drain = 1'b1;
            for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
                if ($urandom_range(9) < 3) begin
                    add_word(hsc_pkg::CMD_ENCODE, hsc_pkg::code_t'($urandom));
                end else begin
                    base = encode_data(hsc_pkg::data_t'($urandom));
                    kind = $urandom_range(9);
                    a = $urandom_range(hsc_pkg::CODE_BITS - 1);
                    b = (a + 1 + $urandom_range(hsc_pkg::CODE_BITS - 2))
                        % hsc_pkg::CODE_BITS;
                    c = $urandom_range(hsc_pkg::CODE_BITS - 1);
                    case (kind)
                        0, 1: w = hsc_pkg::code_t'($urandom);
                        2:    w = base;
                        3, 4, 5: w = base ^ (hsc_pkg::code_t'(1) << a);
                        6, 7: w = base ^ (hsc_pkg::code_t'(1) << a)
                                  ^ (hsc_pkg::code_t'(1) << b);
                        default: w = base ^ (hsc_pkg::code_t'(1) << a)
                                     ^ (hsc_pkg::code_t'(1) << b)
                                     ^ (hsc_pkg::code_t'(1) << c);
                    endcase
                    add_word(hsc_pkg::CMD_DECODE, w);
                end
            end
        end

        // reset
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for the stream to drain, then for the pipeline to settle
        while (queued_words.size() != 0 || s_tvalid || pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
